// ===== rtl/lcds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcds_pkg
// Types and fixed constants of the load compensation DAC setpoint core.
// ----------------------------------------------------------------------------
package lcds_pkg;

	localparam int SampleW = 12;
	localparam int SumW    = 16;
	localparam int CodeW   = 12;

	// Fixed setpoint codes of the two low bands and of the mid band.
	localparam logic [CodeW-1:0] CODE_LOW_BAND  = 12'd3230;
	localparam logic [CodeW-1:0] CODE_LOW2_BAND = 12'd3115;
	localparam logic [CodeW-1:0] CODE_MID_BAND  = 12'd2300;

	// Falling line in Q8: code = (offset - slope * avg) >> 8.
	localparam int LineW = 20;
	localparam int DropW = 23;
	localparam logic [LineW-1:0] LINE_OFFSET_Q8 = 20'd830600;
	localparam logic [10:0]      LINE_SLOPE_Q8  = 11'd1860;

	// Band limits per sample; the window sum is compared with these times the length.
	localparam int LIMIT_LOW    = 5;
	localparam int LIMIT_LOW2   = 20;
	localparam int LIMIT_MID_LO = 100;
	localparam int LIMIT_MID_HI = 200;

	typedef enum logic [1:0] {
		BAND_LOW  = 2'd0,
		BAND_LOW2 = 2'd1,
		BAND_MID  = 2'd2,
		BAND_LINE = 2'd3
	} band_t;

endpackage

// ===== rtl/load_compensation_dac_setpoint_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_compensation_dac_setpoint_core
// Sliding window of ADC load samples mapped to a DAC compensation setpoint.
// ----------------------------------------------------------------------------
// Each input beat carries one 12-bit load sample and yields exactly one output
// beat with the 12-bit DAC setpoint. A new sample is taken in every cycle while
// the output side accepts; each result passes through the window update, band
// select with the average, slope multiply, and final subtract and selection
// stages in that order. The whole pipeline holds while a finished result
// waits, so the sustained rate is one beat per cycle when the output is ready.
// No clearing pass is needed after reset.
module load_compensation_dac_setpoint_core
	import lcds_pkg::*;
#(
	parameter int WINDOW_LENGTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] adc_sample, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [11:0] dac_code, [15:12] zero
);

	localparam longint unsigned RecipL =
		((64'd1 << 32) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
	localparam logic [31:0] RECIP = RecipL[31:0];
	localparam logic [SumW-1:0] LimLow   = SumW'(LIMIT_LOW * WINDOW_LENGTH);
	localparam logic [SumW-1:0] LimLow2  = SumW'(LIMIT_LOW2 * WINDOW_LENGTH);
	localparam logic [SumW-1:0] LimMidLo = SumW'(LIMIT_MID_LO * WINDOW_LENGTH);
	localparam logic [SumW-1:0] LimMidHi = SumW'(LIMIT_MID_HI * WINDOW_LENGTH);

	logic                en;
	logic                s_accept;
	logic [SampleW-1:0]  sample;
	logic [SampleW-1:0]  hist_q [WINDOW_LENGTH];
	logic [SumW-1:0]     sum_q;
	logic [SumW-1:0]     sum_next;
	logic                hist_zero;

	logic                valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [SumW-1:0]     sum_s1;
	logic [47:0]         quot_full;
	band_t               band_sel;
	band_t               band_s2, band_s3;
	logic [SampleW-1:0]  avg_s2;
	logic [DropW-1:0]    drop_s3;
	logic [LineW-1:0]    line_diff;
	logic [CodeW-1:0]    code_next;
	logic [CodeW-1:0]    dac_code_q;

	// The pipeline advances unless a result waits at the output.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign s_accept = s_tvalid && en;
	assign sample   = s_tdata[SampleW-1:0];

	// The sum is zero exactly when every stored sample is zero.
	always_comb begin
		if (sum_q == '0) begin
			sum_next = SumW'({4'd0, sample} * SumW'(WINDOW_LENGTH));
		end else begin
			sum_next = sum_q - SumW'(hist_q[0]) + SumW'(sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) hist_q[i] <= '0;
			sum_q <= '0;
		end else if (s_accept) begin
			sum_q <= sum_next;
			if (sum_q == '0) begin
				for (int i = 0; i < WINDOW_LENGTH; i++) hist_q[i] <= sample;
			end else begin
				for (int i = 0; i < WINDOW_LENGTH - 1; i++) hist_q[i] <= hist_q[i+1];
				hist_q[WINDOW_LENGTH-1] <= sample;
			end
		end
	end

	// Average by reciprocal multiply; exact for every sum the window can hold.
	assign quot_full = 48'(sum_s1) * 48'(RECIP);

	always_comb begin
		if (sum_s1 <= LimLow) begin
			band_sel = BAND_LOW;
		end else if (sum_s1 <= LimLow2) begin
			band_sel = BAND_LOW2;
		end else if (sum_s1 >= LimMidLo && sum_s1 <= LimMidHi) begin
			band_sel = BAND_MID;
		end else begin
			band_sel = BAND_LINE;
		end
	end

	// The offset keeps the shifted line below 4096, so no upper clamp is needed.
	assign line_diff = LINE_OFFSET_Q8 - drop_s3[LineW-1:0];

	always_comb begin
		case (band_s3)
			BAND_LOW:  code_next = CODE_LOW_BAND;
			BAND_LOW2: code_next = CODE_LOW2_BAND;
			BAND_MID:  code_next = CODE_MID_BAND;
			BAND_LINE: begin
				if (drop_s3 >= DropW'(LINE_OFFSET_Q8)) code_next = '0;
				else code_next = line_diff[LineW-1:8];
			end
			default:   code_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= sum_next;
			avg_s2     <= quot_full[32 +: SampleW];
			band_s2    <= band_sel;
			drop_s3    <= DropW'(LINE_SLOPE_Q8) * DropW'(avg_s2);
			band_s3    <= band_s2;
			dac_code_q <= code_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, dac_code_q};

	always_comb begin
		hist_zero = 1'b1;
		for (int i = 0; i < WINDOW_LENGTH; i++) begin
			if (hist_q[i] != '0) hist_zero = 1'b0;
		end
	end

	a_sum_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q == '0) == hist_zero)
		else $error("window sum and history disagree on emptiness");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && sum_q == '0) |=>
			sum_q == SumW'({4'd0, $past(s_tdata[SampleW-1:0])} * SumW'(WINDOW_LENGTH)))
		else $error("refill of an empty window gave a wrong sum");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> dac_code_q <= CODE_LOW_BAND)
		else $error("setpoint above the highest possible code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sum_q) && $stable(dac_code_q))
		else $error("state changed while the pipeline was held");

endmodule
